/* hdl/hrsp_pkg.sv */
`timescale 1ns / 1ps
// Shared types, character codes and helper functions for the HTTP response
// status parser. No dependencies.

package hrsp_pkg;

  // Character codes used by the framer and the converters.
  localparam logic [7:0] CHAR_HT    = 8'h09;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Separator match progress: CR LF CR LF is four characters long.
  localparam logic [2:0] SEP_NONE  = 3'd0;
  localparam logic [2:0] SEP_CR1   = 3'd1;
  localparam logic [2:0] SEP_LF1   = 3'd2;
  localparam logic [2:0] SEP_CR2   = 3'd3;
  localparam logic [2:0] SEP_FULL  = 3'd4;

  // Magnitude cap of the converters and saturated code values.
  localparam logic [15:0] MAG_CAP  = 16'h8000;
  localparam logic [15:0] CODE_MAX = 16'h7FFF;
  localparam logic [15:0] CODE_MIN = 16'h8000;

  // Phase of one atoi style converter.
  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_STOP   = 2'd2
  } conv_phase_t;

  // Per-transfer control handed to the stateful sub-blocks.
  typedef struct packed {
    logic feed;
    logic restart;
  } hrsp_ctl_t;

  // Framing status seen by the top level.
  typedef struct packed {
    logic head_done;
    logic head_done_next;
    logic space_seen;
    logic space_seen_next;
  } hrsp_frame_t;

  // One result item as it travels through the output stage.
  typedef struct packed {
    logic [7:0]        out_byte;
    logic              in_body;
    logic              done_res;
    logic signed [15:0] status_code;
    logic              separator_found;
  } hrsp_result_t;

  // Whitespace by the C library rules: space, HT, LF, VT, FF and CR.
  function automatic logic is_ws(input logic [7:0] b);
    return (b == CHAR_SPACE) || ((b >= CHAR_HT) && (b <= CHAR_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CHAR_ZERO) && (b <= CHAR_NINE);
  endfunction

endpackage

/* hdl/hrsp_conv.sv */
`timescale 1ns / 1ps
// One atoi style status code converter with saturation to 16-bit signed.
// Depends on hrsp_pkg.

module hrsp_conv
  import hrsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  hrsp_ctl_t          ctl,
  input  logic [7:0]         data_byte,
  output logic signed [15:0] code
);

  conv_phase_t phase, phase_next;
  logic        negative, negative_next;
  logic [15:0] value, value_next;
  logic        cr_pending, cr_pending_next;
  logic [19:0] product;
  logic [3:0]  digit;

  assign digit   = data_byte[3:0];
  // Ten times the magnitude plus the new digit; the magnitude never exceeds the cap.
  assign product = {1'b0, value, 3'b000} + {3'b000, value, 1'b0} + {16'd0, digit};

  // Next state for one byte of the head.
  always_comb begin
    phase_next      = phase;
    negative_next   = negative;
    value_next      = value;
    cr_pending_next = cr_pending;
    if (ctl.feed) begin
      case (phase)
        PH_SKIP: begin
          cr_pending_next = 1'b0;
          if (cr_pending && (data_byte == CHAR_LF)) begin
            phase_next = PH_STOP;
          end else if (is_ws(data_byte)) begin
            cr_pending_next = (data_byte == CHAR_CR);
          end else if ((data_byte == CHAR_PLUS) || (data_byte == CHAR_MINUS)) begin
            negative_next = (data_byte == CHAR_MINUS);
            phase_next    = PH_DIGITS;
          end else if (is_digit(data_byte)) begin
            value_next = {12'd0, digit};
            phase_next = PH_DIGITS;
          end else begin
            phase_next = PH_STOP;
          end
        end
        PH_DIGITS: begin
          if (is_digit(data_byte)) begin
            value_next = (product > {4'd0, MAG_CAP}) ? MAG_CAP : product[15:0];
          end else begin
            phase_next = PH_STOP;
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  // Signed code from the updated sign and magnitude.
  always_comb begin
    if (negative_next) begin
      code = (value_next >= MAG_CAP) ? CODE_MIN : (16'd0 - value_next);
    end else begin
      code = (value_next > CODE_MAX) ? CODE_MAX : value_next;
    end
  end

  // Converter state, cleared at reset and after the last byte of a response.
  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      phase      <= PH_SKIP;
      negative   <= 1'b0;
      value      <= 16'd0;
      cr_pending <= 1'b0;
    end else begin
      phase      <= phase_next;
      negative   <= negative_next;
      value      <= value_next;
      cr_pending <= cr_pending_next;
    end
  end

endmodule

/* hdl/hrsp_framer.sv */
`timescale 1ns / 1ps
// Header framing: tracks the CR LF CR LF separator and the first space of the
// head. Depends on hrsp_pkg.

module hrsp_framer
  import hrsp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  hrsp_ctl_t   ctl,
  input  logic [7:0]  data_byte,
  output hrsp_frame_t frame
);

  logic [2:0] sep_progress, sep_progress_next;
  logic       head_done;
  logic       space_seen;

  // Separator match: a CR restarts or extends the match, an LF extends it.
  always_comb begin
    if (data_byte == CHAR_CR) begin
      sep_progress_next = (sep_progress == SEP_LF1) ? SEP_CR2 : SEP_CR1;
    end else if ((data_byte == CHAR_LF) &&
                 ((sep_progress == SEP_CR1) || (sep_progress == SEP_CR2))) begin
      sep_progress_next = sep_progress + 3'd1;
    end else begin
      sep_progress_next = SEP_NONE;
    end
  end

  // Status as it stands before and after the current byte.
  always_comb begin
    frame.head_done       = head_done;
    frame.space_seen      = space_seen;
    frame.head_done_next  = head_done || (sep_progress_next == SEP_FULL);
    frame.space_seen_next = space_seen || (!head_done && (data_byte == CHAR_SPACE));
  end

  // Framing state only moves while the head is still being received.
  always_ff @(posedge clk) begin
    if (rst || ctl.restart) begin
      sep_progress <= SEP_NONE;
      head_done    <= 1'b0;
      space_seen   <= 1'b0;
    end else if (ctl.feed && !head_done) begin
      sep_progress <= sep_progress_next;
      head_done    <= frame.head_done_next;
      space_seen   <= frame.space_seen_next;
    end
  end

endmodule

/* hdl/hrsp_out_stage.sv */
`timescale 1ns / 1ps
// Result register with a skid entry, so a new transfer is taken while a
// finished result waits. Depends on hrsp_pkg.

module hrsp_out_stage
  import hrsp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  hrsp_result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_stall,
  output hrsp_result_t out_data
);

  logic         skid_valid;
  hrsp_result_t skid_data;
  logic         take;

  assign take = out_valid && !out_stall;
  // Upstream is held only once the skid entry is occupied.
  assign full = skid_valid;

  // Valid flags of the two entries.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      out_valid  <= skid_valid || push;
      skid_valid <= 1'b0;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload of the two entries.
  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_valid) begin
        out_data <= skid_data;
      end else if (push) begin
        out_data <= push_data;
      end
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

/* hdl/http_response_status_parser.sv */
`timescale 1ns / 1ps
// HTTP response status parser: byte-wide head/body marking and status code
// extraction. Depends on hrsp_pkg, hrsp_framer, hrsp_conv and hrsp_out_stage.
//
// Usage:
//   The input channel (in_valid, in_stall, data_byte, last_byte) carries one
//   byte of the response per transfer, last_byte marking its final byte. The
//   output channel (out_valid, out_stall and the result fields) returns one
//   result per input byte, in order: the byte itself, whether it lies in the
//   body, the done flag, the separator flag and, on the last byte, the status
//   code (0 when no CR LF CR LF was seen).
//   Each result is registered before it is output; one byte is taken every
//   cycle while in_stall is low, and the per-byte state update of the
//   framer and the two converters runs in the same cycle as the input.
//   A result register and a skid entry follow that logic: when the receiver
//   stalls, one more byte is still taken, and in_stall rises while both
//   entries are full. in_stall is registered and does not follow out_stall
//   combinationally.
//   Synchronous reset empties the output stage and returns the framer and
//   converters to their initial state; the last byte of a response does the
//   same to the parsing state, so the next byte starts a new response.

module http_response_status_parser
  import hrsp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               in_body,
  output logic               done_res,
  output logic signed [15:0] status_code,
  output logic               separator_found
);

  logic               accept;
  hrsp_ctl_t          frame_ctl;
  hrsp_ctl_t          main_ctl;
  hrsp_ctl_t          fallback_ctl;
  hrsp_frame_t        frame;
  logic signed [15:0] main_code;
  logic signed [15:0] fallback_code;
  hrsp_result_t       result;
  hrsp_result_t       out_data;

  assign accept = in_valid && !in_stall;

  // Control for the stateful parts; the main converter starts after the first space.
  always_comb begin
    frame_ctl.feed       = accept;
    frame_ctl.restart    = accept && last_byte;
    main_ctl.feed        = accept && !frame.head_done && frame.space_seen;
    main_ctl.restart     = frame_ctl.restart;
    fallback_ctl.feed    = accept && !frame.head_done;
    fallback_ctl.restart = frame_ctl.restart;
  end

  hrsp_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .ctl       (frame_ctl),
    .data_byte (data_byte),
    .frame     (frame)
  );

  hrsp_conv u_main_conv (
    .clk       (clk),
    .rst       (rst),
    .ctl       (main_ctl),
    .data_byte (data_byte),
    .code      (main_code)
  );

  hrsp_conv u_fallback_conv (
    .clk       (clk),
    .rst       (rst),
    .ctl       (fallback_ctl),
    .data_byte (data_byte),
    .code      (fallback_code)
  );

  // Assemble the result for the byte being transferred.
  always_comb begin
    result.out_byte        = data_byte;
    result.in_body         = frame.head_done;
    result.done_res        = last_byte;
    result.separator_found = frame.head_done_next;
    if (last_byte && frame.head_done_next) begin
      result.status_code = frame.space_seen_next ? main_code : fallback_code;
    end else begin
      result.status_code = 16'sd0;
    end
  end

  hrsp_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign out_byte        = out_data.out_byte;
  assign in_body         = out_data.in_body;
  assign done_res        = out_data.done_res;
  assign status_code     = out_data.status_code;
  assign separator_found = out_data.separator_found;

endmodule

/* hdl/hrsp_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the HTTP response status parser, bound to the top
// level. Depends on http_response_status_parser.

module hrsp_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic [7:0]         out_byte,
  input logic               in_body,
  input logic               done_res,
  input logic signed [15:0] status_code,
  input logic               separator_found
);

  // A stalled result stays in place with the same byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte))
    else $error("stalled result changed");

  // A code is only reported on the last byte of a response.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !done_res |-> status_code == 16'sd0)
    else $error("status code outside the last byte");

  // Body bytes only follow a completed separator.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && in_body |-> separator_found)
    else $error("body byte without separator");

  // A response without a separator reports a zero code.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !separator_found |-> status_code == 16'sd0)
    else $error("code reported without separator");

  // Reset empties the output.
  assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind http_response_status_parser hrsp_checker u_hrsp_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte        (out_byte),
  .in_body         (in_body),
  .done_res        (done_res),
  .status_code     (status_code),
  .separator_found (separator_found)
);
